// File: sv/change_journal_overlap_query_macros.svh
// ----------------------------------------------------------------------------
// Change journal overlap query: assertion macros
// Concurrent assertion wrappers shared by the block; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CHANGE_JOURNAL_OVERLAP_QUERY_MACROS_SVH
`define CHANGE_JOURNAL_OVERLAP_QUERY_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define CJOQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define CJOQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CJOQ_ASSERT(lbl, clk, rst, prop, msg)
`define CJOQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: sv/cjoq_pkg.sv
// ----------------------------------------------------------------------------
// Change journal overlap query: package
// Shared constants, the journal entry layout and the compare unit's outputs.
// ----------------------------------------------------------------------------
package cjoq_pkg;

  localparam int CJOQ_DEPTH = 256;

  localparam logic [2:0] KIND_CHANGED = 3'd3;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] revision;
    logic [2:0]  kind;
  } entry_t;

  typedef struct packed {
    logic newer;  // entry revision above the query revision
    logic hit;    // a 'changed' entry whose region overlaps the query
  } match_t;

endpackage

// File: sv/cjoq_ram.sv
// ----------------------------------------------------------------------------
// Change journal overlap query: journal memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cjoq_ram #(
  parameter int DEPTH = cjoq_pkg::CJOQ_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  cjoq_pkg::entry_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output cjoq_pkg::entry_t rd_data
);
  import cjoq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/cjoq_match.sv
// ----------------------------------------------------------------------------
// Change journal overlap query: entry compare unit
// Compares one journal entry against the query revision and region.
// ----------------------------------------------------------------------------
module cjoq_match (
  input  cjoq_pkg::entry_t entry,
  input  logic [31:0]      q_offset,
  input  logic [31:0]      q_length,
  input  logic [31:0]      q_revision,
  output cjoq_pkg::match_t result
);
  import cjoq_pkg::*;

  logic [32:0] e_end;
  logic [32:0] q_end;

  // Region ends are formed at 33 bits so that they never wrap.
  assign e_end = {1'b0, entry.offset} + {1'b0, entry.length};
  assign q_end = {1'b0, q_offset} + {1'b0, q_length};

  assign result.newer = entry.revision > q_revision;
  assign result.hit   = (entry.kind == KIND_CHANGED) &&
                        (e_end > {1'b0, q_offset}) &&
                        (q_end > {1'b0, entry.offset});

endmodule

// File: sv/change_journal_overlap_query.sv
// ----------------------------------------------------------------------------
// Change journal overlap query: top level
// Ring journal of region changes with a sequenced, entry-by-entry overlap walk.
// ----------------------------------------------------------------------------
// Records never raise busy; a record may follow every cycle while no query holds busy.
// A query in sync, or on an empty journal, is answered straight from idle, and one older
// than the whole journal once its oldest entry is read. Otherwise the walk compares
// entries from the newest onwards until one is not newer than the query, one overlaps,
// or it runs out at the oldest entry; the single read port feeds one entry per cycle.
// Busy falls as the result is shown; results cannot be stalled; reset empties the journal.
module change_journal_overlap_query #(
  parameter int DEPTH = cjoq_pkg::CJOQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [2:0]  change_type,
  input  logic [31:0] region_offset,
  input  logic [31:0] region_length,
  input  logic [31:0] query_revision,
  input  logic [31:0] current_revision,
  output logic        result_valid,
  output logic        region_changed
);
  import cjoq_pkg::*;

  `include "change_journal_overlap_query_macros.svh"

  localparam int          AW   = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  // The ring grows downwards: a record goes in the slot just before the
  // newest one, and the walk moves upwards from the newest entry.
  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? LAST : i - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == LAST) ? '0 : i + AW'(1);
  endfunction

  typedef enum logic [1:0] {
    S_IDLE,
    S_OLDEST,
    S_WALK
  } state_t;

  state_t        state;
  logic [AW-1:0] newest;
  logic [AW-1:0] end_idx;
  logic [AW-1:0] ptr;
  logic [31:0]   q_offset;
  logic [31:0]   q_length;
  logic [31:0]   q_revision;

  logic          accept;
  logic          rec_accept;
  logic          qry_accept;
  logic [AW-1:0] rec_slot;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  match_t        match;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign rec_accept = accept && !kind;
  assign qry_accept = accept && kind;
  assign rec_slot   = ring_prev(newest);

  assign wr_data.offset   = region_offset;
  assign wr_data.length   = region_length;
  assign wr_data.revision = current_revision;
  assign wr_data.kind     = change_type;

  // Read address sequencing. On acceptance the oldest entry is fetched for
  // the early "older than the whole journal" test; while that answer is
  // being checked the newest entry is fetched, and during the walk the
  // entry after the one under test is fetched, so one entry is compared
  // every cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ring_next(ptr);
    unique case (state)
      S_IDLE: begin
        rd_en   = qry_accept;
        rd_addr = ring_prev(end_idx);
      end
      S_OLDEST: begin
        rd_en   = 1'b1;
        rd_addr = newest;
      end
      S_WALK: begin
        rd_en   = 1'b1;
        rd_addr = ring_next(ptr);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = ring_next(ptr);
      end
    endcase
  end

  cjoq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (rec_accept),
    .wr_addr (rec_slot),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The one compare unit serves both the oldest-entry test and the walk.
  cjoq_match u_match (
    .entry      (rd_data),
    .q_offset   (q_offset),
    .q_length   (q_length),
    .q_revision (q_revision),
    .result     (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      newest       <= '0;
      end_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (rec_accept) begin
            newest <= rec_slot;
            // Coming full circle drops the oldest entry.
            if (rec_slot == end_idx) begin
              end_idx <= ring_prev(end_idx);
            end
          end else if (qry_accept) begin
            q_offset   <= region_offset;
            q_length   <= region_length;
            q_revision <= query_revision;
            if (query_revision >= current_revision || newest == end_idx) begin
              // Caller already in sync, or nothing has been journalled.
              result_valid   <= 1'b1;
              region_changed <= 1'b0;
            end else begin
              state <= S_OLDEST;
            end
          end
        end
        S_OLDEST: begin
          if (match.newer) begin
            // The query predates the whole journal: assume a change.
            result_valid   <= 1'b1;
            region_changed <= 1'b1;
            state          <= S_IDLE;
          end else begin
            ptr   <= newest;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (ptr == end_idx || !match.newer) begin
            result_valid   <= 1'b1;
            region_changed <= 1'b0;
            state          <= S_IDLE;
          end else if (match.hit) begin
            result_valid   <= 1'b1;
            region_changed <= 1'b1;
            state          <= S_IDLE;
          end else begin
            ptr <= ring_next(ptr);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result is only ever presented once the sequencer has gone back to idle.
  `CJOQ_ASSERT(a_result_when_idle, clk, rst, result_valid |-> !busy, "result while busy")

  // A record never produces a result.
  `CJOQ_ASSERT(a_record_silent, clk, rst, rec_accept |=> !result_valid, "record gave result")

  // A query whose revision is not older than the current one answers 0 next cycle.
  `CJOQ_ASSERT(a_in_sync_zero, clk, rst,
               (qry_accept && query_revision >= current_revision) |=>
                 (result_valid && !region_changed),
               "in-sync query not answered 0")

  // A result follows either a query accepted just before or a busy cycle.
  `CJOQ_ASSERT(a_result_cause, clk, rst,
               result_valid |-> ($past(qry_accept) || $past(busy)),
               "unexpected result")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Change journal overlap query: testbench
// Drives record and query items through the start/busy handshake, predicts
// every answer from a journal model of its own, and checks each result strobe.
// ----------------------------------------------------------------------------
module tb;
  import cjoq_pkg::*;

  // What one item asks of the block.
  localparam logic ITEM_RECORD = 1'b0;
  localparam logic ITEM_QUERY  = 1'b1;

  // The 'begin' change type, which the payload holds before the first item.
  localparam logic [2:0] CT_BEGIN   = 3'd0;

  localparam int RING = CJOQ_DEPTH;
  // Longest query walk plus the cycles around it.
  localparam int WALK_CYCLES = RING + 8;

  logic        clk;
  logic        rst              = 1'b1;
  logic        start            = 1'b0;
  logic        kind             = ITEM_RECORD;
  logic [2:0]  change_type      = CT_BEGIN;
  logic [31:0] region_offset    = 32'd0;
  logic [31:0] region_length    = 32'd0;
  logic [31:0] query_revision   = 32'd0;
  logic [31:0] current_revision = 32'd0;
  logic        busy;
  logic        result_valid;
  logic        region_changed;

  change_journal_overlap_query dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (kind),
    .change_type      (change_type),
    .region_offset    (region_offset),
    .region_length    (region_length),
    .query_revision   (query_revision),
    .current_revision (current_revision),
    .result_valid     (result_valid),
    .region_changed   (region_changed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Journal model. The newest entry sits at jrn_newest; jrn_tail is the slot
  // just past the oldest one, and the two are equal when the journal is empty.
  // New entries are pushed backwards round the ring, so a walk from newest to
  // oldest goes forwards.
  // ---------------------------------------------------------------------------
  logic [31:0] jrn_offset   [RING];
  logic [31:0] jrn_length   [RING];
  logic [31:0] jrn_revision [RING];
  logic [2:0]  jrn_type     [RING];
  int unsigned jrn_newest = 0;
  int unsigned jrn_tail   = 0;

  // Answers still owed by the block, oldest first.
  logic        changed_due[$];
  logic        due_bit;

  logic [31:0] rev_now;
  int          mismatches   = 0;
  int          records_sent = 0;
  int          queries_sent = 0;
  int          answers_seen = 0;
  int          answers_hit  = 0;
  int          entries_lost = 0;

  function automatic int unsigned ring_back(input int unsigned i);
    return (i + RING - 1) % RING;
  endfunction

  function automatic int unsigned ring_fwd(input int unsigned i);
    return (i + 1) % RING;
  endfunction

  function automatic void journal_push(input logic [2:0] ct, input logic [31:0] off,
                                       input logic [31:0] len, input logic [31:0] rev);
    jrn_newest               = ring_back(jrn_newest);
    jrn_offset[jrn_newest]   = off;
    jrn_length[jrn_newest]   = len;
    jrn_revision[jrn_newest] = rev;
    jrn_type[jrn_newest]     = ct;
    // The ring has come full circle: the oldest entry falls out.
    if (jrn_newest == jrn_tail) begin
      jrn_tail = ring_back(jrn_tail);
      entries_lost++;
    end
  endfunction

  function automatic logic region_changed_after(input logic [31:0] off, input logic [31:0] len,
                                                input logic [31:0] qrev, input logic [31:0] crev);
    logic [32:0] q_end;
    logic [32:0] e_end;
    int unsigned i;
    int unsigned steps;
    // A caller already in sync, or a journal with nothing in it, sees no change.
    if (qrev >= crev || jrn_newest == jrn_tail) return 1'b0;
    // A revision older than anything the journal still holds must be treated as
    // changed, since the history it needs has been dropped.
    if (qrev < jrn_revision[ring_back(jrn_tail)]) return 1'b1;
    // Region ends are formed one bit wider, so a region running past the top of
    // the offset space does not wrap round to a small end.
    q_end = {1'b0, off} + {1'b0, len};
    i     = jrn_newest;
    steps = 0;
    while (i != jrn_tail && jrn_revision[i] > qrev && steps < RING) begin
      e_end = {1'b0, jrn_offset[i]} + {1'b0, jrn_length[i]};
      if (jrn_type[i] == KIND_CHANGED && e_end > {1'b0, off} &&
          q_end > {1'b0, jrn_offset[i]}) return 1'b1;
      i = ring_fwd(i);
      steps++;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake. Fields and start are driven just after a rising edge; the item
  // is taken at the first later edge at which busy was low, which is the value
  // read here before the edge's own updates land. Start is left high so that a
  // following item can go back to back; idle_cycles lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic k, input logic [2:0] ct, input logic [31:0] off,
                           input logic [31:0] len, input logic [31:0] qrev,
                           input logic [31:0] crev);
    start            <= 1'b1;
    kind             <= k;
    change_type      <= ct;
    region_offset    <= off;
    region_length    <= len;
    query_revision   <= qrev;
    current_revision <= crev;
    do @(posedge clk); while (busy);
    if (k == ITEM_RECORD) begin
      journal_push(ct, off, len, crev);
      records_sent++;
    end else begin
      changed_due.push_back(region_changed_after(off, len, qrev, crev));
      queries_sent++;
    end
  endtask

  task automatic record_change(input logic [2:0] ct, input logic [31:0] off,
                               input logic [31:0] len, input logic [31:0] rev);
    // The query revision is meaningless here, so it carries noise.
    send_item(ITEM_RECORD, ct, off, len, $urandom, rev);
  endtask

  task automatic query_region(input logic [31:0] off, input logic [31:0] len,
                              input logic [31:0] qrev, input logic [31:0] crev);
    // Likewise the change type of a query.
    send_item(ITEM_QUERY, 3'($urandom), off, len, qrev, crev);
  endtask

  // Start goes low and the payload carries junk, which the block must ignore.
  task automatic idle_cycles(input int n);
    start            <= 1'b0;
    kind             <= 1'($urandom);
    change_type      <= 3'($urandom);
    region_offset    <= $urandom;
    region_length    <= $urandom;
    query_revision   <= $urandom;
    current_revision <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Every strobe is held against the oldest answer owed.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      answers_seen++;
      if (region_changed === 1'b1) answers_hit++;
      if (changed_due.size() == 0) begin
        report_mismatch("result strobe with no query outstanding");
      end else begin
        due_bit = changed_due.pop_front();
        if (region_changed !== due_bit)
          report_mismatch($sformatf("region_changed %b, expected %b (answer %0d)",
                                    region_changed, due_bit, answers_seen));
      end
    end
  end

  // Mostly a small window, so that regions overlap often; now and then regions
  // at the very top of the offset space, empty ones, or anything at all.
  task automatic pick_region(output logic [31:0] off, output logic [31:0] len);
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        off = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        len = $urandom_range(0, 8192);
      end
      3, 4: begin
        off = $urandom_range(0, 4095);
        len = 32'd0;
      end
      5, 6, 7: begin
        off = $urandom;
        len = $urandom;
      end
      default: begin
        off = $urandom_range(0, 4095);
        len = $urandom_range(0, 256);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // A query on an empty journal answers 'unchanged' whatever the revisions.
  task automatic test_empty_journal();
    query_region(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    idle_cycles(3);
  endtask

  // A query revision equal to or above the current one never walks.
  task automatic test_query_not_older();
    record_change(KIND_CHANGED, 32'd100, 32'd10, 32'd50);
    query_region(32'd100, 32'd10, 32'd50, 32'd50);
    query_region(32'd100, 32'd10, 32'd60, 32'd51);
    query_region(32'd100, 32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Only 'changed' entries count: the other named types and the three unnamed
  // codes above 'end' are stored and walked past. Regions that merely touch do
  // not overlap.
  task automatic test_change_types();
    for (int t = 0; t < 8; t++) begin
      if (3'(t) != KIND_CHANGED) record_change(3'(t), 32'd1000, 32'd16, 32'd60);
    end
    query_region(32'd1000, 32'd16, 32'd55, 32'd61);
    idle_cycles(1);
    record_change(KIND_CHANGED, 32'd2000, 32'd8, 32'd61);
    query_region(32'd2007, 32'd1, 32'd55, 32'd62);
    query_region(32'd2008, 32'd5, 32'd55, 32'd62);
  endtask

  // A revision below the oldest entry held is answered 'changed' at once.
  task automatic test_before_oldest();
    query_region(32'd0, 32'd1, 32'd10, 32'd100);
  endtask

  // Region ends above 32 bits, empty regions on both sides of the test, and
  // revisions at both ends of their range.
  task automatic test_extremes();
    record_change(KIND_CHANGED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd70);
    query_region(32'h0, 32'hFFFF_FFFF, 32'd65, 32'd71);
    query_region(32'hFFFF_FFFE, 32'd2, 32'd65, 32'd71);
    idle_cycles(2);
    record_change(KIND_CHANGED, 32'h5000, 32'd0, 32'd80);
    query_region(32'h4000, 32'h2000, 32'd75, 32'd81);
    record_change(KIND_CHANGED, 32'h100, 32'h100, 32'hFFFF_FFFF);
    query_region(32'h180, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    query_region(32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
  endtask

  // ---------------------------------------------------------------------------
  // Random test. Most records carry a slowly rising revision, as a real file
  // would, so that queries walk part of the history and stop at the revision
  // asked about; the ring fills and wraps several times over. A few records
  // carry a revision out of order, and a few queries ask for a revision at or
  // above the current one, or anything at all. The sender idles in bursts
  // whose density changes every fifty items, none at all in some stretches.
  // ---------------------------------------------------------------------------
  task automatic test_random_sequences(input int n_items, input bit with_gaps);
    logic [31:0] off;
    logic [31:0] len;
    logic [31:0] qrev;
    logic [31:0] crev;
    logic [2:0]  ct;
    int          gap_pct;
    int          roll;
    gap_pct = 0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 50 == 0) gap_pct = with_gaps ? 30 * $urandom_range(0, 2) : 0;
      roll = $urandom_range(0, 99);
      pick_region(off, len);
      if (roll < 62) begin
        rev_now += $urandom_range(0, 3);
        ct = $urandom_range(0, 1) ? KIND_CHANGED : 3'($urandom);
        record_change(ct, off, len, rev_now);
      end else if (roll < 66) begin
        record_change(3'($urandom), off, len, $urandom);
      end else begin
        crev = rev_now + $urandom_range(0, 2);
        case ($urandom_range(0, 9))
          0:       qrev = $urandom;
          1:       qrev = crev + $urandom_range(0, 3);
          default: qrev = rev_now - $urandom_range(0, 420);
        endcase
        query_region(off, len, qrev, crev);
      end
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        idle_cycles($urandom_range(1, 10));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int guard;
    rev_now = $urandom_range(1000, 32'hFFF0_0000);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_journal();
    test_query_not_older();
    test_change_types();
    test_before_oldest();
    test_extremes();
    idle_cycles(4);
    test_random_sequences(1550, 1'b1);
    // The last part runs with the sender never pausing.
    test_random_sequences(200, 1'b0);
    idle_cycles(1);

    // Drain: wait for the answers still owed, then a walk's length besides, so
    // that a stray late strobe is caught too.
    guard = 0;
    while (changed_due.size() != 0 && guard < 4 * WALK_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (WALK_CYCLES) @(posedge clk);
    if (changed_due.size() != 0)
      report_mismatch($sformatf("%0d queries never answered", changed_due.size()));

    $display("Run covered %0d records and %0d queries (%0d answered changed);",
             records_sent, queries_sent, answers_hit);
    $display("the journal dropped its oldest entry %0d times, %0d mismatches.",
             entries_lost, mismatches);
    if (mismatches == 0) begin
      $display("** change_journal_overlap_query: PASSED **");
    end else begin
      $display("** change_journal_overlap_query: FAILED **");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run: every item a full walk
  // plus the longest idle burst.
  initial begin
    #20_000_000;
    $display("Timeout: the run did not finish.");
    $display("** change_journal_overlap_query: FAILED **");
    $finish;
  end

endmodule
